[hw/rtl/maze_backtracker_generator_defines.svh]
// Assertion helpers shared by the maze carver RTL.
`ifndef MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define MBG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define MBG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/mbg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbg_pkg;

   // default grid edge length in cells
   localparam int CELLS_PER_SIDE_DEF = 16;

   // fixed port widths
   localparam int COORD_W = 4;
   localparam int DIR_W   = 2;
   localparam int CSR_W   = 4;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_X = 1'd0,
      REG_START_Y = 1'd1
   } csr_reg_type;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CLEAR    = 8'b0000_0010,
      ST_MARK     = 8'b0000_0100,
      ST_CHECK_RD = 8'b0000_1000,
      ST_CHECK_WT = 8'b0001_0000,
      ST_DECIDE   = 8'b0010_0000,
      ST_POP_WT   = 8'b0100_0000,
      ST_EMIT     = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/maze_backtracker_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
//  channel   | ports                                            | dir | handshake
//  ----------+--------------------------------------------------+-----+------------------
//  request   | req_restart, req_direction                       | in  | req_valid/stall
//  response  | rsp_from_x/y, rsp_to_x/y, rsp_carved_dir, _last  | out | rsp_valid/stall
//  csr       | csr_index, csr_wdata                             | in  | csr_wr_en
//
//  Restart request: all G = 2^(2*clog2(CELLS_PER_SIDE)) visited-map entries are cleared
//    one per cycle (256 entries at 16x16), then the start cell is marked.
//  Draw request: a four-neighbor scan and decide, then per pop a stack read and rescan,
//    then the emit step; the scan reads through the single visited-map read port.
//  req_stall is low only in idle; a finished response waits in its own register,
//    so rsp_stall stalls the core only when a second response is ready to load.
//  reset is synchronous; after reset draws are ignored until the first restart.

module maze_backtracker_generator
   import mbg_pkg::*;
#(
   parameter int CELLS_PER_SIDE = CELLS_PER_SIDE_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_restart,
   input  wire logic [DIR_W-1:0]     req_direction,
   // response channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [COORD_W-1:0]   rsp_from_x,
   output      logic [COORD_W-1:0]   rsp_from_y,
   output      logic [COORD_W-1:0]   rsp_to_x,
   output      logic [COORD_W-1:0]   rsp_to_y,
   output      logic [DIR_W-1:0]     rsp_carved_dir,
   output      logic                 rsp_last,
   // configuration writes
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

`include "maze_backtracker_generator_defines.svh"

   // geometry
   localparam int CW         = $clog2(CELLS_PER_SIDE);       // coordinate bits
   localparam int MAW        = 2 * CW;                       // {y,x} cell address
   localparam int MAP_DEPTH  = 1 << MAW;
   localparam int CELL_COUNT = CELLS_PER_SIDE * CELLS_PER_SIDE;
   localparam int SAW        = $clog2(CELL_COUNT);           // stack address
   localparam int DW         = $clog2(CELL_COUNT + 1);       // stack depth
   localparam int CDW        = $clog2(CELL_COUNT + 1);       // visited count

   // control state
   state_type         state_ff,    state_in;
   logic [CW-1:0]     walker_x_ff, walker_x_in;
   logic [CW-1:0]     walker_y_ff, walker_y_in;
   logic [DW-1:0]     depth_ff,    depth_in;
   logic [CDW-1:0]    cells_ff,    cells_in;
   logic              finished_ff, finished_in;
   dir_type           dir_ff,      dir_in;       // drawn direction
   logic [1:0]        scan_ff,     scan_in;      // neighbor being scanned
   logic [3:0]        open_ff,     open_in;      // unvisited in-bounds neighbors
   logic [MAW-1:0]    clr_ff,      clr_in;       // clear sweep pointer
   logic [CSR_W-1:0]  start_x_ff,  start_x_in;
   logic [CSR_W-1:0]  start_y_ff,  start_y_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_load;
   logic [COORD_W-1:0] rsp_from_x_ff, rsp_from_y_ff, rsp_to_x_ff, rsp_to_y_ff;
   logic [DIR_W-1:0]  rsp_dir_ff;
   logic              rsp_last_ff, rsp_last_in;

   // memories
   logic              visited_ff [MAP_DEPTH];
   logic [MAW-1:0]    stack_ff   [CELL_COUNT];
   logic              vis_rdata_ff;
   logic [MAW-1:0]    stk_rdata_ff;
   logic              vis_we, vis_wdata, vis_re;
   logic [MAW-1:0]    vis_waddr, vis_raddr;
   logic              stk_we, stk_re;
   logic [SAW-1:0]    stk_addr;
   logic [MAW-1:0]    stk_wdata;

   // shared neighbor unit: one incrementer/decrementer with its edge compare
   dir_type           nb_sel;
   logic              nb_vert, nb_dec, nb_ok;
   logic [CW-1:0]     nb_coord, nb_step, nb_x, nb_y;
   logic [DW-1:0]     depth_dec;
   logic              req_fire;

   assign nb_sel   = (state_ff == ST_EMIT) ? dir_ff : dir_type'(scan_ff);
   assign nb_vert  = (nb_sel == DIR_UP)   || (nb_sel == DIR_DOWN);
   assign nb_dec   = (nb_sel == DIR_UP)   || (nb_sel == DIR_LEFT);
   assign nb_coord = nb_vert ? walker_y_ff : walker_x_ff;
   assign nb_ok    = nb_dec ? (nb_coord != '0) : (nb_coord != CW'(CELLS_PER_SIDE - 1));
   assign nb_step  = nb_dec ? (nb_coord - CW'(1)) : (nb_coord + CW'(1));
   assign nb_x     = nb_vert ? walker_x_ff : nb_step;
   assign nb_y     = nb_vert ? nb_step : walker_y_ff;

   assign depth_dec = depth_ff - DW'(1);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // configuration writes
   always_comb begin
      start_x_in = start_x_ff;
      start_y_in = start_y_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_START_X: start_x_in = csr_wdata;
            REG_START_Y: start_y_in = csr_wdata;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      walker_x_in  = walker_x_ff;
      walker_y_in  = walker_y_ff;
      depth_in     = depth_ff;
      cells_in     = cells_ff;
      finished_in  = finished_ff;
      dir_in       = dir_ff;
      scan_in      = scan_ff;
      open_in      = open_ff;
      clr_in       = clr_ff;
      rsp_load     = 1'b0;
      rsp_last_in  = 1'b0;
      vis_we       = 1'b0;
      vis_wdata    = 1'b0;
      vis_waddr    = {nb_y, nb_x};
      vis_re       = 1'b0;
      vis_raddr    = {nb_y, nb_x};
      stk_we       = 1'b0;
      stk_re       = 1'b0;
      stk_addr     = depth_ff[SAW-1:0];
      stk_wdata    = {walker_y_ff, walker_x_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_restart) begin
                  // start cell saturates to the last row/column
                  walker_x_in = (32'(start_x_ff) < 32'(CELLS_PER_SIDE)) ?
                                CW'(start_x_ff) : CW'(CELLS_PER_SIDE - 1);
                  walker_y_in = (32'(start_y_ff) < 32'(CELLS_PER_SIDE)) ?
                                CW'(start_y_ff) : CW'(CELLS_PER_SIDE - 1);
                  depth_in    = '0;
                  cells_in    = CDW'(1);
                  finished_in = 1'b0;
                  clr_in      = '0;
                  state_in    = ST_CLEAR;
               end else if (!finished_ff) begin
                  dir_in   = dir_type'(req_direction);
                  scan_in  = '0;
                  open_in  = '0;
                  state_in = ST_CHECK_RD;
               end
            end
         end
         ST_CLEAR: begin
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            clr_in    = clr_ff + MAW'(1);
            if (clr_ff == '1) begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            vis_we    = 1'b1;
            vis_wdata = 1'b1;
            vis_waddr = {walker_y_ff, walker_x_ff};
            state_in  = ST_IDLE;
         end
         ST_CHECK_RD: begin
            if (nb_ok) begin
               vis_re   = 1'b1;
               state_in = ST_CHECK_WT;
            end else if (scan_ff == 2'd3) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + 2'd1;
            end
         end
         ST_CHECK_WT: begin
            open_in[scan_ff] = ~vis_rdata_ff;
            if (scan_ff == 2'd3) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in  = scan_ff + 2'd1;
               state_in = ST_CHECK_RD;
            end
         end
         ST_DECIDE: begin
            if (open_ff == '0) begin
               if (depth_ff == '0) begin
                  // dead end with an empty stack: maze complete
                  finished_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  depth_in = depth_dec;
                  stk_re   = 1'b1;
                  stk_addr = depth_dec[SAW-1:0];
                  state_in = ST_POP_WT;
               end
            end else if (open_ff[dir_ff]) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;   // blocked draw
            end
         end
         ST_POP_WT: begin
            walker_x_in = stk_rdata_ff[CW-1:0];
            walker_y_in = stk_rdata_ff[MAW-1:CW];
            scan_in     = '0;
            open_in     = '0;
            state_in    = ST_CHECK_RD;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load  = 1'b1;
               if (depth_ff < DW'(CELL_COUNT)) begin
                  stk_we   = 1'b1;
                  depth_in = depth_ff + DW'(1);
               end
               vis_we      = 1'b1;
               vis_wdata   = 1'b1;
               cells_in    = cells_ff + CDW'(1);
               if (cells_ff >= CDW'(CELL_COUNT - 1)) begin
                  rsp_last_in = 1'b1;
                  finished_in = 1'b1;
               end
               walker_x_in = nb_x;
               walker_y_in = nb_y;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         walker_x_ff  <= '0;
         walker_y_ff  <= '0;
         depth_ff     <= '0;
         cells_ff     <= '0;
         finished_ff  <= 1'b1;
         dir_ff       <= DIR_UP;
         scan_ff      <= '0;
         open_ff      <= '0;
         clr_ff       <= '0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walker_x_ff  <= walker_x_in;
         walker_y_ff  <= walker_y_in;
         depth_ff     <= depth_in;
         cells_ff     <= cells_in;
         finished_ff  <= finished_in;
         dir_ff       <= dir_in;
         scan_ff      <= scan_in;
         open_ff      <= open_in;
         clr_ff       <= clr_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_from_x_ff <= COORD_W'(walker_x_ff);
         rsp_from_y_ff <= COORD_W'(walker_y_ff);
         rsp_to_x_ff   <= COORD_W'(nb_x);
         rsp_to_y_ff   <= COORD_W'(nb_y);
         rsp_dir_ff    <= dir_ff;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   // visited map: one write, one registered read
   always_ff @(posedge clock) begin
      if (vis_we) begin
         visited_ff[vis_waddr] <= vis_wdata;
      end
      if (vis_re) begin
         vis_rdata_ff <= visited_ff[vis_raddr];
      end
   end

   // backtrack stack: single address, registered read
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_ff[stk_addr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rdata_ff <= stack_ff[stk_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_from_x     = rsp_from_x_ff;
   assign rsp_from_y     = rsp_from_y_ff;
   assign rsp_to_x       = rsp_to_x_ff;
   assign rsp_to_y       = rsp_to_y_ff;
   assign rsp_carved_dir = rsp_dir_ff;
   assign rsp_last       = rsp_last_ff;

   // every cell on the stack was counted as visited, plus the walker's own
   `MBG_ASSERT_IMPLY(a_depth_below_count, clock, reset, !finished_ff, depth_ff < DW'(cells_ff), "stack deeper than visited count")
   // a new response only comes out of the emit step
   `MBG_ASSERT_NEXT(a_rsp_from_emit, clock, reset, !rsp_valid_ff && state_ff != ST_EMIT, !rsp_valid_ff, "response raised outside emit")
   // the scan never runs on a finished maze
   `MBG_ASSERT_IMPLY(a_scan_live, clock, reset, state_ff == ST_CHECK_RD || state_ff == ST_DECIDE, !finished_ff, "neighbor scan while finished")
   // walker stays on the grid
   `MBG_ASSERT_IMPLY(a_walker_in_grid, clock, reset, 1'b1, 32'(walker_x_ff) < 32'(CELLS_PER_SIDE) && 32'(walker_y_ff) < 32'(CELLS_PER_SIDE), "walker off grid")

endmodule

`default_nettype wire

[verif/tb_maze_backtracker_generator.sv]
`timescale 1ns / 1ps

// Maze carver bench: a directed table first (idle draws, edges, restarts, a
// dead-end pocket that forces backtracking), then random phases with most
// draws steered toward open cells so whole mazes get carved to the goal.
module tb_maze_backtracker_generator;
   import mbg_pkg::*;

   localparam int SIDE           = CELLS_PER_SIDE_DEF;
   localparam int CELLS          = SIDE * SIDE;
   // Worst idle draw: a full-depth backtrack plus the scan.
   localparam int SETTLE_CYCLES  = 3000;
   localparam int HOLD_CYCLES    = 600;     // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 20000;   // cycles with no handshake at all
   localparam int PHASES         = 3;
   localparam int PHASE_ITEMS    = 400;

   typedef struct packed {
      logic [COORD_W-1:0] from_x;
      logic [COORD_W-1:0] from_y;
      logic [COORD_W-1:0] to_x;
      logic [COORD_W-1:0] to_y;
      dir_type            carved_dir;
      logic               last;
   } passage_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;
   typedef enum logic [1:0] {EXP_NONE, EXP_TYPED, EXP_MODEL} outcome_type;

   // A CSR row only uses cfg_x/cfg_y; a request row uses the rest.
   typedef struct packed {
      row_kind_type       kind;
      logic               restart;
      dir_type            dir;
      outcome_type        outcome;
      logic [COORD_W-1:0] cfg_x;
      logic [COORD_W-1:0] cfg_y;
      passage_type        want;
   } stim_row_type;

   localparam passage_type NO_CARVE = '0;
   localparam int TABLE_ROWS = 25;

   // Directed part. Typed rows are the obvious carves; the two rows after the
   // dead end at (0,0) need the backtrack, so the predictor covers them.
   localparam stim_row_type STIM_TABLE [TABLE_ROWS] = '{
      // idle after reset: draws are dropped until the first restart
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_RIGHT, EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      // restart at (0,0), direction ignored
      '{ROW_REQ, 1'b1, DIR_DOWN,  EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      // top and left edges block
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_LEFT,  EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_RIGHT, EXP_TYPED, 4'd0, 4'd0,
        '{4'd0, 4'd0, 4'd1, 4'd0, DIR_RIGHT, 1'b0}},
      // back into a visited cell
      '{ROW_REQ, 1'b0, DIR_LEFT,  EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_DOWN,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd1, 4'd0, 4'd1, 4'd1, DIR_DOWN, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_LEFT,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd1, 4'd1, 4'd0, 4'd1, DIR_LEFT, 1'b0}},
      // far corner: bottom and right edges block; restart mid-maze
      '{ROW_CSR, 1'b0, DIR_UP,    EXP_NONE,  4'd15, 4'd15, NO_CARVE},
      '{ROW_REQ, 1'b1, DIR_UP,    EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_DOWN,  EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_RIGHT, EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_TYPED, 4'd0, 4'd0,
        '{4'd15, 4'd15, 4'd15, 4'd14, DIR_UP, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_LEFT,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd15, 4'd14, 4'd14, 4'd14, DIR_LEFT, 1'b0}},
      // pocket: walk (1,0)->(1,1)->(1,2)->(0,2)->(0,1)->(0,0), a dead end
      '{ROW_CSR, 1'b0, DIR_UP,    EXP_NONE,  4'd1, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b1, DIR_RIGHT, EXP_NONE,  4'd0, 4'd0, NO_CARVE},
      '{ROW_REQ, 1'b0, DIR_DOWN,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd1, 4'd0, 4'd1, 4'd1, DIR_DOWN, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_DOWN,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd1, 4'd1, 4'd1, 4'd2, DIR_DOWN, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_LEFT,  EXP_TYPED, 4'd0, 4'd0,
        '{4'd1, 4'd2, 4'd0, 4'd2, DIR_LEFT, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_TYPED, 4'd0, 4'd0,
        '{4'd0, 4'd2, 4'd0, 4'd1, DIR_UP, 1'b0}},
      '{ROW_REQ, 1'b0, DIR_UP,    EXP_TYPED, 4'd0, 4'd0,
        '{4'd0, 4'd1, 4'd0, 4'd0, DIR_UP, 1'b0}},
      // two pops back to (0,2), then the draw hits a visited cell
      '{ROW_REQ, 1'b0, DIR_RIGHT, EXP_MODEL, 4'd0, 4'd0, NO_CARVE},
      // pops stuck: carve down from (0,2)
      '{ROW_REQ, 1'b0, DIR_DOWN,  EXP_MODEL, 4'd0, 4'd0, NO_CARVE}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic [DIR_W-1:0]     req_direction = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COORD_W-1:0]   rsp_from_x;
   logic [COORD_W-1:0]   rsp_from_y;
   logic [COORD_W-1:0]   rsp_to_x;
   logic [COORD_W-1:0]   rsp_to_y;
   logic [DIR_W-1:0]     rsp_carved_dir;
   logic                 rsp_last;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   maze_backtracker_generator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .req_direction  (req_direction),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y),
      .rsp_carved_dir (rsp_carved_dir),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Maze predictor: its own copy of the visited map, the backtrack trail,
   // the walker and the start cell. Values below match the reset state.
   // ---------------------------------------------------------------------
   bit                 visited [CELLS];
   int                 trail [CELLS];
   int                 trail_depth = 0;
   int                 walker_x = 0;
   int                 walker_y = 0;
   int                 cells_done = 0;
   bit                 maze_done = 1'b1;    // idle until the first restart
   logic [COORD_W-1:0] start_x_cfg = '0;
   logic [COORD_W-1:0] start_y_cfg = '0;

   passage_type pending_passages [$];

   int  fail_count = 0;
   int  requests_sent = 0;
   int  random_requests = 0;
   int  passages_checked = 0;
   int  mazes_carved = 0;
   int  backtrack_pops = 0;
   int  burst_left = 0;
   bit  hold_request = 1'b0;
   int  quiet_cycles = 0;

   // Neighbor cell in direction d; 0 when it falls off the grid.
   function automatic bit neighbor_of(input int x, input int y, input dir_type d,
                                      output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
         DIR_UP: begin
            if (y == 0) return 1'b0;
            ny = y - 1;
         end
         DIR_DOWN: begin
            if (y + 1 >= SIDE) return 1'b0;
            ny = y + 1;
         end
         DIR_LEFT: begin
            if (x == 0) return 1'b0;
            nx = x - 1;
         end
         default: begin
            if (x + 1 >= SIDE) return 1'b0;
            nx = x + 1;
         end
      endcase
      return 1'b1;
   endfunction

   // One bit per direction: in bounds and not yet visited.
   function automatic logic [3:0] open_dirs(input int x, input int y);
      logic [3:0] mask;
      int nx, ny;
      mask = '0;
      for (int d = 0; d < 4; d++)
         if (neighbor_of(x, y, dir_type'(d), nx, ny))
            mask[d] = !visited[ny * SIDE + nx];
      return mask;
   endfunction

   // Directions that would carve on the next draw, after any backtracking.
   function automatic logic [3:0] carvable_dirs();
      int x, y, depth;
      x = walker_x;
      y = walker_y;
      depth = trail_depth;
      if (maze_done) return '0;
      while (open_dirs(x, y) == 0 && depth > 0) begin
         depth--;
         x = trail[depth] % SIDE;
         y = trail[depth] / SIDE;
      end
      return open_dirs(x, y);
   endfunction

   // Advance the maze by one request; returns 1 with the passage when one is carved.
   function automatic bit carve_step(input logic restart, input dir_type d,
                                     output passage_type p);
      logic [3:0] mask;
      int nx, ny;
      p = '0;
      if (restart) begin
         for (int i = 0; i < CELLS; i++) visited[i] = 1'b0;
         trail_depth = 0;
         walker_x = (start_x_cfg < SIDE) ? int'(start_x_cfg) : SIDE - 1;
         walker_y = (start_y_cfg < SIDE) ? int'(start_y_cfg) : SIDE - 1;
         visited[walker_y * SIDE + walker_x] = 1'b1;
         cells_done = 1;
         maze_done = 1'b0;
         return 1'b0;
      end
      if (maze_done) return 1'b0;
      // backtrack until the walker has somewhere to go
      while (open_dirs(walker_x, walker_y) == 0) begin
         if (trail_depth == 0) begin
            maze_done = 1'b1;
            return 1'b0;
         end
         trail_depth--;
         walker_x = trail[trail_depth] % SIDE;
         walker_y = trail[trail_depth] / SIDE;
         backtrack_pops++;
      end
      mask = open_dirs(walker_x, walker_y);
      if (!mask[d]) return 1'b0;
      void'(neighbor_of(walker_x, walker_y, d, nx, ny));
      if (trail_depth < CELLS) begin
         trail[trail_depth] = walker_y * SIDE + walker_x;
         trail_depth++;
      end
      visited[ny * SIDE + nx] = 1'b1;
      cells_done++;
      p.from_x     = walker_x[COORD_W-1:0];
      p.from_y     = walker_y[COORD_W-1:0];
      p.to_x       = nx[COORD_W-1:0];
      p.to_y       = ny[COORD_W-1:0];
      p.carved_dir = d;
      p.last       = (cells_done >= CELLS);
      if (p.last) maze_done = 1'b1;
      walker_x = nx;
      walker_y = ny;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: bursts of random length with random gaps in between.
   // more = 0 drops valid once this request is taken (end of a phase).
   // ---------------------------------------------------------------------
   task automatic offer(input logic restart, input dir_type dir, input bit more);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid     <= 1'b1;
      req_restart   <= restart;
      req_direction <= dir;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      burst_left--;
      if (!more) burst_left = 0;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   // Start cell writes happen only with the block idle: drain, then let any
   // trailing backtrack (no response) finish before touching the registers.
   task automatic set_start(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      while (pending_passages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= REG_START_X;
      csr_wdata <= x;
      @(posedge clock);
      csr_index <= REG_START_Y;
      csr_wdata <= y;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      start_x_cfg = x;
      start_y_cfg = y;
   endtask

   // ---------------------------------------------------------------------
   // Response side: stall pattern of its own, plus one long hold-off so the
   // output register and the core both fill and the request side backs up.
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int mode;
      int len;
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 80);
            for (int i = 0; i < len; i++) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                  2:       rsp_stall <= ($urandom_range(0, 9) < 7);
                  default: rsp_stall <= i[0];
               endcase
               @(posedge clock);
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [3:0] want,
                              input logic [3:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   // Passage checker: every accepted response against the oldest prediction.
   always @(posedge clock) begin : passage_check
      passage_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_passages.size() == 0) begin
            $error("unexpected passage (%0d,%0d)->(%0d,%0d)",
                   rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y);
            fail_count++;
         end else begin
            head = pending_passages.pop_front();
            check_field("from_x", head.from_x, rsp_from_x);
            check_field("from_y", head.from_y, rsp_from_y);
            check_field("to_x", head.to_x, rsp_to_x);
            check_field("to_y", head.to_y, rsp_to_y);
            check_field("carved_dir", 4'(head.carved_dir), 4'(rsp_carved_dir));
            check_field("last", 4'(head.last), 4'(rsp_last));
            passages_checked++;
         end
      end
   end

   // Watchdog: any handshake on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type       row;
      passage_type        carve;
      bit                 carved;
      bit                 more;
      bit                 fresh;
      bit                 idle_before;
      logic               restart;
      dir_type            d;
      logic [3:0]         mask;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      int                 counted;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < TABLE_ROWS; i++) begin
         row = STIM_TABLE[i];
         if (row.kind == ROW_CSR) begin
            set_start(row.cfg_x, row.cfg_y);
         end else begin
            more = (i + 1 < TABLE_ROWS) && (STIM_TABLE[i + 1].kind == ROW_REQ);
            offer(row.restart, row.dir, more);
            carved = carve_step(row.restart, row.dir, carve);
            if (row.outcome == EXP_TYPED) begin
               pending_passages.push_back(row.want);
            end else if (row.outcome == EXP_MODEL && carved) begin
               pending_passages.push_back(carve);
            end
         end
      end

      // random phases: two opposite corners, then a random start cell
      for (int ph = 0; ph < PHASES; ph++) begin
         px = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom_range(0, 15));
         py = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         set_start(px, py);
         counted = 0;
         fresh = 1'b1;
         while (counted < PHASE_ITEMS) begin
            if (fresh) restart = 1'b1;
            else if (maze_done) restart = ($urandom_range(0, 2) == 0);
            else restart = ($urandom_range(0, 499) == 0);   // rare restart mid-maze
            // mostly steer toward a cell that carves; the rest is plain noise
            mask = carvable_dirs();
            if (!restart && mask != 0 && $urandom_range(0, 9) != 0) begin
               do d = dir_type'($urandom_range(0, 3)); while (!mask[d]);
            end else begin
               d = dir_type'($urandom_range(0, 3));
            end
            if (ph == 0 && counted == 150) hold_request = 1'b1;
            idle_before = maze_done;
            offer(restart, d, counted + 1 < PHASE_ITEMS);
            fresh = 1'b0;
            if (carve_step(restart, d, carve)) begin
               pending_passages.push_back(carve);
               if (carve.last) mazes_carved++;
            end
            // draws into a finished maze are dropped and do not count
            if (restart || !idle_before) begin
               counted++;
               random_requests++;
            end
         end
      end

      while (pending_passages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d requests (%0d random), %0d passages checked, %0d mazes to goal",
               requests_sent, random_requests, passages_checked, mazes_carved);
      $display("run: %0d backtrack pops, start cells at corners, edges and random",
               backtrack_pops);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
